@@ rtl/psched_pkg.sv @@
// ----------------------------------------------------------------------------
// psched_pkg
// Types and codes shared by the periodic task scheduler and its slot cells.
// ----------------------------------------------------------------------------
package psched_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_ENABLE   = 3'd1,
        OP_DISABLE  = 3'd2,
        OP_REQUEST  = 3'd3,
        OP_TICK     = 3'd4,
        OP_DISPATCH = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NONE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] period;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] dispatched_slot;
        logic [7:0] ready_mask;
    } t_out_item;

    // item travelling down the row of slot cells
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic [2:0] slot;
        logic       hit;
        logic [2:0] chosen;
    } t_tok;

endpackage

@@ rtl/periodic_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit
// Priority-ordered table of periodic task slots built as a row of cells.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------
//  command  | in        | i_start and !o_busy | i_item  (op, slot, period)
//  result   | out       | o_valid, one cycle  | o_result (status, slot, mask)
//
// An item enters through an input register, then walks the row of SLOTS
// cells, one cell per cycle; its result shows as it leaves the last cell,
// and no new item is taken before the result cycle. Synchronous reset clears all
// slots. The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit #(
    parameter int SLOTS       = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  psched_pkg::t_in_item  i_item,
    output logic                  o_busy,
    output logic                  o_valid,
    output psched_pkg::t_out_item o_result
);

    psched_pkg::t_tok       w_tok [0:SLOTS];
    logic [SLOTS-1:0]       w_ready;
    psched_pkg::t_tok       r_tok0, n_tok0;
    logic                   r_busy, n_busy;
    logic [PERIOD_BITS-1:0] r_period;
    logic [31:0]            w_per32;
    logic                   w_accept;
    logic                   w_done;
    logic [SLOTS:0]         w_valids;
    logic [7:0]             w_mask;

    assign w_done   = w_tok[SLOTS].valid;
    assign o_busy   = r_busy && !w_done;
    assign w_accept = i_start && !o_busy;
    assign w_per32  = 32'(i_item.period);

    always_comb begin
        n_tok0 = '0;
        if (w_accept) begin
            n_tok0.valid = 1'b1;
            n_tok0.op    = i_item.op;
            n_tok0.slot  = i_item.slot;
        end
        n_busy = w_accept ? 1'b1 : (w_done ? 1'b0 : r_busy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0 <= '0;
            r_busy <= 1'b0;
        end else begin
            r_tok0 <= n_tok0;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_period <= w_per32[PERIOD_BITS-1:0];
        end
    end

    assign w_tok[0] = r_tok0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        psched_cell #(
            .INDEX       (g),
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_period (r_period),
            .o_tok    (w_tok[g+1]),
            .o_ready  (w_ready[g])
        );
    end

    for (genvar b = 0; b < 8; b++) begin : g_mask
        if (b < SLOTS) begin : g_used
            assign w_mask[b] = w_ready[b];
        end else begin : g_unused
            assign w_mask[b] = 1'b0;
        end
    end

    for (genvar v = 0; v <= SLOTS; v++) begin : g_valid
        assign w_valids[v] = w_tok[v].valid;
    end

    always_comb begin
        o_result.status          = psched_pkg::ST_DONE;
        o_result.dispatched_slot = 3'd0;
        o_result.ready_mask      = w_mask;
        unique case (w_tok[SLOTS].op)
            psched_pkg::OP_ADD: begin
                if (!w_tok[SLOTS].hit) begin
                    o_result.status = psched_pkg::ST_REJECT;
                end
            end
            psched_pkg::OP_DISPATCH: begin
                if (w_tok[SLOTS].hit) begin
                    o_result.dispatched_slot = w_tok[SLOTS].chosen;
                end else begin
                    o_result.status = psched_pkg::ST_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = w_done;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valids))
        else $error("more than one item in the cell row");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result without an item in flight");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_tok0.valid && r_busy)
        else $error("accepted item did not enter the row");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status != 2'd3))
        else $error("status code out of range");

    a_dispatch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_tok[SLOTS].op == psched_pkg::OP_DISPATCH) && w_tok[SLOTS].hit)
        |-> !o_result.ready_mask[o_result.dispatched_slot])
        else $error("dispatched slot still ready");

endmodule

@@ rtl/psched_cell.sv @@
// ----------------------------------------------------------------------------
// psched_cell
// One task slot: holds its flags, period and countdown, applies the item
// passing through and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module psched_cell #(
    parameter int INDEX       = 0,
    parameter int PERIOD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psched_pkg::t_tok       i_tok,
    input  logic [PERIOD_BITS-1:0] i_period,
    output psched_pkg::t_tok       o_tok,
    output logic                   o_ready
);

    localparam logic [2:0] SLOT_ID   = 3'(INDEX);
    localparam bit         REACHABLE = (INDEX < 8);

    logic                   r_installed, n_installed;
    logic                   r_enabled, n_enabled;
    logic                   r_ready, n_ready;
    logic [PERIOD_BITS-1:0] r_countdown, n_countdown;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    psched_pkg::t_tok       r_tok, n_tok;

    logic                   w_match;
    logic [PERIOD_BITS-1:0] w_dec;

    assign w_match = REACHABLE && (i_tok.slot == SLOT_ID);
    assign w_dec   = r_countdown - PERIOD_BITS'(1);

    always_comb begin
        n_installed = r_installed;
        n_enabled   = r_enabled;
        n_ready     = r_ready;
        n_countdown = r_countdown;
        n_period    = r_period;
        n_tok       = i_tok;
        if (i_tok.valid) begin
            unique case (i_tok.op)
                psched_pkg::OP_ADD: begin
                    if (w_match && !r_installed) begin
                        n_installed = 1'b1;
                        n_enabled   = 1'b1;
                        n_ready     = 1'b0;
                        n_countdown = i_period;
                        n_period    = i_period;
                        n_tok.hit   = 1'b1;
                    end
                end
                psched_pkg::OP_ENABLE: begin
                    if (w_match) begin
                        n_enabled = 1'b1;
                    end
                end
                psched_pkg::OP_DISABLE: begin
                    if (w_match) begin
                        n_enabled = 1'b0;
                    end
                end
                psched_pkg::OP_REQUEST: begin
                    if (w_match) begin
                        n_ready = 1'b1;
                    end
                end
                psched_pkg::OP_TICK: begin
                    if (r_installed && r_enabled && (r_countdown != '0)) begin
                        if (w_dec == '0) begin
                            n_ready     = 1'b1;
                            n_countdown = r_period;
                        end else begin
                            n_countdown = w_dec;
                        end
                    end
                end
                psched_pkg::OP_DISPATCH: begin
                    if (!i_tok.hit && r_installed && r_enabled && r_ready) begin
                        n_ready      = 1'b0;
                        n_tok.hit    = 1'b1;
                        n_tok.chosen = SLOT_ID;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_installed <= 1'b0;
            r_enabled   <= 1'b0;
            r_ready     <= 1'b0;
            r_countdown <= '0;
            r_period    <= '0;
            r_tok       <= '0;
        end else begin
            r_installed <= n_installed;
            r_enabled   <= n_enabled;
            r_ready     <= n_ready;
            r_countdown <= n_countdown;
            r_period    <= n_period;
            r_tok       <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_ready = r_ready;

endmodule

@@ dv/periodic_task_scheduler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit_tb
// Self-checking bench for the periodic task scheduler. Items go in through
// the start/busy handshake with random gaps. A slot table tracker predicts
// each result: status, dispatched slot and ready mask. One result is checked
// per item, in order, as it is strobed out.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit_tb;

    localparam int SLOTS       = 8;
    localparam int PERIOD_BITS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM  = 1600;

    // op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    class slot_table_tracker;
        bit                    installed [SLOTS];
        bit                    enabled   [SLOTS];
        bit                    ready     [SLOTS];
        logic [15:0]           countdown [SLOTS];
        logic [15:0]           period    [SLOTS];
        psched_pkg::t_out_item awaited [$];
        int                    mismatches;

        function new();
            mismatches = 0;
            foreach (countdown[i]) begin
                countdown[i] = '0;
                period[i]    = '0;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void apply_command(psched_pkg::t_in_item cmd);
            psched_pkg::t_out_item res;
            int                    s;
            res        = '0;
            res.status = psched_pkg::ST_DONE;
            s          = cmd.slot;
            case (cmd.op)
                psched_pkg::OP_ADD: begin
                    if (installed[s]) begin
                        res.status = psched_pkg::ST_REJECT;
                    end else begin
                        installed[s] = 1'b1;
                        enabled[s]   = 1'b1;
                        ready[s]     = 1'b0;
                        countdown[s] = cmd.period;
                        period[s]    = cmd.period;
                    end
                end
                psched_pkg::OP_ENABLE:  enabled[s] = 1'b1;
                psched_pkg::OP_DISABLE: enabled[s] = 1'b0;
                psched_pkg::OP_REQUEST: ready[s]   = 1'b1;
                psched_pkg::OP_TICK: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (installed[i] && enabled[i] && countdown[i] != '0) begin
                            countdown[i] = countdown[i] - 16'd1;
                            if (countdown[i] == '0) begin
                                ready[i]     = 1'b1;
                                countdown[i] = period[i];
                            end
                        end
                    end
                end
                psched_pkg::OP_DISPATCH: begin
                    res.status = psched_pkg::ST_NONE;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (installed[i] && enabled[i] && ready[i]) begin
                            ready[i]            = 1'b0;
                            res.dispatched_slot = 3'(i);
                            res.status          = psched_pkg::ST_DONE;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < SLOTS; i++)
                res.ready_mask[i] = ready[i];
            awaited.push_back(res);
        endfunction

        function void flag(string what, psched_pkg::t_out_item want,
                           psched_pkg::t_out_item got);
            if (mismatches < 10)
                $display("%s: exp st %0d sl %0d mask %02h, act st %0d sl %0d mask %02h",
                         what, want.status, want.dispatched_slot, want.ready_mask,
                         got.status, got.dispatched_slot, got.ready_mask);
            mismatches++;
        endfunction

        function void compare_result(psched_pkg::t_out_item got);
            psched_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.dispatched_slot !== want.dispatched_slot ||
                got.ready_mask !== want.ready_mask)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    psched_pkg::t_in_item  i_item;
    logic                  o_busy;
    logic                  o_valid;
    psched_pkg::t_out_item o_result;

    slot_table_tracker tracker;
    int unsigned       cycle_count = 0;
    bit                burst       = 1'b0;

    periodic_task_scheduler_unit #(
        .SLOTS       (SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid)
                tracker.compare_result(o_result);
            if (i_start && !o_busy)
                tracker.apply_command(i_item);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input psched_pkg::t_in_item cmd);
        int gap;
        int r;
        i_item  <= cmd;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic [2:0] op, input logic [2:0] slot, input logic [15:0] per);
        psched_pkg::t_in_item cmd;
        cmd.op     = op;
        cmd.slot   = slot;
        cmd.period = per;
        send_item(cmd);
    endtask

    initial begin
        int          r;
        logic [2:0]  op;
        logic [15:0] per;

        tracker = new();
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, flags on slots not yet installed
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_TICK,     3'd0, 16'hFFFF);
        issue(psched_pkg::OP_REQUEST,  3'd3, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_DISABLE,  3'd3, 16'h0000);
        issue(psched_pkg::OP_ENABLE,   3'd5, 16'h0000);
        // installs, occupied slot, period extremes
        issue(psched_pkg::OP_ADD,      3'd0, 16'h0001);
        issue(psched_pkg::OP_ADD,      3'd0, 16'h0004);
        issue(psched_pkg::OP_ADD,      3'd1, 16'h0000);
        issue(psched_pkg::OP_ADD,      3'd7, 16'hFFFF);
        issue(psched_pkg::OP_ADD,      3'd2, 16'h0003);
        issue(psched_pkg::OP_TICK,     3'd0, 16'h0000);
        issue(psched_pkg::OP_TICK,     3'd0, 16'h0000);
        issue(psched_pkg::OP_TICK,     3'd0, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_REQUEST,  3'd1, 16'h0000);
        issue(psched_pkg::OP_DISABLE,  3'd0, 16'h0000);
        issue(psched_pkg::OP_TICK,     3'd0, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(psched_pkg::OP_ENABLE,   3'd0, 16'h0000);
        issue(psched_pkg::OP_DISPATCH, 3'd0, 16'h0000);
        issue(OP_SPARE_A,              3'd7, 16'hA5A5);
        issue(OP_SPARE_B,              3'd2, 16'h5A5A);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == NUM_RANDOM / 2) begin
                i_start <= 1'b0;
                while (tracker.pending() != 0)
                    @(posedge i_clk);
            end
            per = 16'($urandom_range(0, 65535));
            r   = $urandom_range(0, 99);
            if (r < 8) begin
                op = psched_pkg::OP_ADD;
                r  = $urandom_range(0, 99);
                if (r < 60)
                    per = 16'($urandom_range(1, 6));
                else if (r < 75)
                    per = '0;
            end else if (r < 16) begin
                op = psched_pkg::OP_ENABLE;
            end else if (r < 22) begin
                op = psched_pkg::OP_DISABLE;
            end else if (r < 30) begin
                op = psched_pkg::OP_REQUEST;
            end else if (r < 62) begin
                op = psched_pkg::OP_TICK;
            end else if (r < 95) begin
                op = psched_pkg::OP_DISPATCH;
            end else begin
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            end
            issue(op, 3'($urandom_range(0, 7)), per);
        end

        i_start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (2 * SLOTS + 4) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
